// ===== rtl/adcm_pkg.sv =====
// Package with the constants, types and byte functions of the entropy byte mixer.
`default_nettype none

package adcm_pkg;

   // Number of sample pairs folded into one output byte (1 .. 8).
   localparam int PAIRS_PER_BYTE = 4;

   // Pair index counter width; at least one bit so the counter always exists.
   localparam int IDX_W = (PAIRS_PER_BYTE > 1) ? $clog2(PAIRS_PER_BYTE) : 1;

   localparam int SAMPLE_W = 10;
   localparam int BYTE_W   = 8;
   localparam int ROT_W    = 3;

   // History mixing shift amounts.
   localparam int HIST_SHR_A = 3;
   localparam int HIST_SHL   = 5;
   localparam int HIST_SHR_B = 4;

   localparam logic [ROT_W-1:0] RIGHT_ROT_BASE = ROT_W'(7);
   localparam logic [IDX_W-1:0] LAST_INDEX     = IDX_W'(PAIRS_PER_BYTE - 1);

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [SAMPLE_W-1:0] sample_type;
   typedef logic [IDX_W-1:0]    index_type;
   typedef logic [ROT_W-1:0]    rot_type;

   // Rotate a byte left by 0 .. 7 places.
   function automatic byte_type rotl8(input byte_type v, input rot_type amount);
      logic [2*BYTE_W-1:0] both;
      both = {v, v} << amount;
      return both[2*BYTE_W-1:BYTE_W];
   endfunction

   // One push onto the left stack.
   function automatic byte_type push_left(input byte_type s, input logic b);
      return (s << 1) ^ {{(BYTE_W-1){1'b0}}, b} ^ s;
   endfunction

   // One push onto the right stack.
   function automatic byte_type push_right(input byte_type s, input logic b);
      return (s >> 1) ^ {b, {(BYTE_W-1){1'b0}}} ^ s;
   endfunction

   // History byte folded with its own shifts.
   function automatic byte_type mix_history(input byte_type h);
      return h ^ (h >> HIST_SHR_A) ^ (h << HIST_SHL) ^ (h >> HIST_SHR_B);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/adcm_req_if.sv =====
// Stream interface carrying one pair of converter samples per transfer.
`default_nettype none

interface adcm_req_if;
   logic                   valid;
   logic                   ready;
   adcm_pkg::sample_type   left_sample;
   adcm_pkg::sample_type   right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/adcm_rsp_if.sv =====
// Stream interface carrying one mixed random byte per transfer.
`default_nettype none

interface adcm_rsp_if;
   logic                 valid;
   logic                 ready;
   adcm_pkg::byte_type   random_byte;

   modport source (output valid, output random_byte, input ready);
   modport sink   (input valid, input random_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/adc_entropy_byte_mixer.sv =====
// Top level of the entropy byte mixer for pairs of noisy converter samples.
//
//   Channel | Direction | Payload                        | Handshake
//   --------+-----------+--------------------------------+-------------
//   req     | in        | left_sample, right_sample (10) | valid/ready
//   rsp     | out       | random_byte (8)                | valid/ready
//
// A sample pair is captured in an input register on its transfer and is
// folded into the mixer state as it leaves that register, so one pair can
// be taken every cycle unless a byte is stalled at the output. A random
// byte is loaded into the output register as the last pair of each group
// of PAIRS_PER_BYTE pairs leaves the input register. Reset is synchronous
// and clears all state but the payload registers. While the output register
// holds an unclaimed byte, a captured pair waits for rsp.ready and req.ready then follows rsp.ready.
`default_nettype none

module adc_entropy_byte_mixer (
   input  wire logic  clock,
   input  wire logic  reset,
   adcm_req_if.sink   req,
   adcm_rsp_if.source rsp
);
   import adcm_pkg::*;

   // Input register: the captured pair, of which only the low byte matters.
   logic      in_valid_ff, in_valid_in;
   byte_type  left_ff, left_in;
   byte_type  right_ff, right_in;

   // Mixer state.
   byte_type  left_stack_ff, left_stack_in;
   byte_type  right_stack_ff, right_stack_in;
   byte_type  history_ff, history_in;
   byte_type  accum_ff, accum_in;
   index_type pair_index_ff, pair_index_in;
   logic      stack_choice_ff, stack_choice_in;

   // Output register.
   logic      rsp_valid_ff, rsp_valid_in;
   byte_type  rsp_byte_ff, rsp_byte_in;

   logic      advance;
   logic      group_start;
   logic      group_last;
   logic      choice;
   rot_type   left_rot;
   byte_type  accum_new;
   byte_type  left_stack_new;
   byte_type  right_stack_new;
   byte_type  history_new;

   // The captured pair moves on unless a finished byte is still waiting.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   assign group_start = (pair_index_ff == '0);
   assign group_last  = (pair_index_ff == LAST_INDEX);

   always_comb begin
      // The stack is chosen once per group, from the stacks as they stand
      // before the first pair of the group is pushed.
      choice   = group_start ? (left_stack_ff[0] ^ right_stack_ff[0]) : stack_choice_ff;
      left_rot = ROT_W'(pair_index_ff);

      accum_new = (group_start ? '0 : accum_ff)
                  ^ rotl8(left_ff, left_rot)
                  ^ rotl8(right_ff, RIGHT_ROT_BASE - left_rot);

      // Every bit position where the samples differ pushes the left bit,
      // from bit 0 upwards, onto the chosen stack.
      left_stack_new  = left_stack_ff;
      right_stack_new = right_stack_ff;
      for (int j = 0; j < BYTE_W; j++) begin
         if (left_ff[j] != right_ff[j]) begin
            if (!choice) begin
               left_stack_new = push_left(left_stack_new, left_ff[j]);
            end else begin
               right_stack_new = push_right(right_stack_new, left_ff[j]);
            end
         end
      end

      history_new = mix_history(history_ff) ^ accum_new;
   end

   always_comb begin
      in_valid_in     = in_valid_ff;
      left_in         = left_ff;
      right_in        = right_ff;
      left_stack_in   = left_stack_ff;
      right_stack_in  = right_stack_ff;
      history_in      = history_ff;
      accum_in        = accum_ff;
      pair_index_in   = pair_index_ff;
      stack_choice_in = stack_choice_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_byte_in     = rsp_byte_ff;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         in_valid_in     = 1'b0;
         left_stack_in   = left_stack_new;
         right_stack_in  = right_stack_new;
         stack_choice_in = choice;
         if (group_last) begin
            // End of group: fold the accumulator into the history and
            // present the new byte.
            history_in    = history_new;
            accum_in      = '0;
            pair_index_in = '0;
            rsp_valid_in  = 1'b1;
            rsp_byte_in   = history_new ^ left_stack_new ^ right_stack_new;
         end else begin
            accum_in      = accum_new;
            pair_index_in = pair_index_ff + 1'b1;
         end
      end

      if (req.valid && req.ready) begin
         in_valid_in = 1'b1;
         left_in     = req.left_sample[BYTE_W-1:0];
         right_in    = req.right_sample[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         left_stack_ff   <= '0;
         right_stack_ff  <= '0;
         history_ff      <= '0;
         accum_ff        <= '0;
         pair_index_ff   <= '0;
         stack_choice_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         left_stack_ff   <= left_stack_in;
         right_stack_ff  <= right_stack_in;
         history_ff      <= history_in;
         accum_ff        <= accum_in;
         pair_index_ff   <= pair_index_in;
         stack_choice_ff <= stack_choice_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.random_byte = rsp_byte_ff;

endmodule

`default_nettype wire

// ===== rtl/adcm_checker.sv =====
// Port-level checker for the entropy byte mixer, bound to its top level.
`default_nettype none

module adcm_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire adcm_pkg::byte_type rsp_random_byte
);
   import adcm_pkg::*;

   // A stalled byte stays offered and unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_random_byte))
      else $error("stalled random byte dropped or changed");

   // Nothing is offered straight after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("random byte offered after reset");

   // Input back-pressure only comes from a byte waiting at the output.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input stalled without output back-pressure");

   // A new byte always follows a pair transfer that passed through the input register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("random byte without a preceding pair transfer");

endmodule

bind adc_entropy_byte_mixer adcm_checker u_adcm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_random_byte (rsp.random_byte)
);

`default_nettype wire
